### sv/flpkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flpkc_pkg;

    // Default sizes for the top level
    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int DEF_PROBE_LIMIT   = 8;
    localparam int DEF_QUEUE_DEPTH   = 2;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 16;
    localparam int SLOT_W     = 16;
    localparam int HASH_W     = 32;

    // FNV-1a over the ten key bytes
    localparam int                KEY_BYTES = 10;
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET   = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // One hashed operation travelling from front to back
    typedef struct packed {
        t_cmd                  cmd;
        logic [KEY_LOW_W-1:0]  key_low;
        logic [KEY_HIGH_W-1:0] key_high;
        logic [SLOT_W-1:0]     slot;
        logic [HASH_W-1:0]     hash;
    } t_job;

    // One table entry
    typedef struct packed {
        logic                  valid;
        logic [KEY_LOW_W-1:0]  key_low;
        logic [KEY_HIGH_W-1:0] key_high;
        logic [SLOT_W-1:0]     slot;
    } t_entry;

endpackage

`default_nettype wire

### sv/flpkc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface flpkc_in_if;
    import flpkc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [KEY_LOW_W-1:0]  key_low;
    logic [KEY_HIGH_W-1:0] key_high;
    logic [SLOT_W-1:0]     slot_value;

    modport source (output valid, command, key_low, key_high, slot_value, input ready);
    modport sink   (input valid, command, key_low, key_high, slot_value, output ready);
endinterface

interface flpkc_out_if;
    import flpkc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot_found;
    logic              evicted;

    modport source (output valid, hit, slot_found, evicted, input ready);
    modport sink   (input valid, hit, slot_found, evicted, output ready);
endinterface

`default_nettype wire

### sv/fnv_linear_probe_key_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Key-to-slot cache: a 10-byte key is hashed with 32-bit FNV-1a and looked up
// in a TABLE_ENTRIES-deep table (a power of two) with up to PROBE_LIMIT
// linear probes, one more for put. Get returns hit and the stored slot, put
// inserts or updates and flags an eviction when the probes run out, clear
// empties the table. The front takes no new item until it is through with
// the last: a transfer, ten hash steps through a single 32x32 multiplier,
// then a push into a small queue that waits while the queue is full. The
// back makes k table reads per get or put, 1..PROBE_LIMIT for get and
// 1..PROBE_LIMIT+1 for put, one read per cycle on the single table read port.
// A clear command returns its result at once and then sweeps the whole table.
// After reset the same sweep runs with input ready held low.
module fnv_linear_probe_key_cache_top #(
    parameter int TABLE_ENTRIES = flpkc_pkg::DEF_TABLE_ENTRIES,
    parameter int PROBE_LIMIT   = flpkc_pkg::DEF_PROBE_LIMIT,
    parameter int QUEUE_DEPTH   = flpkc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    flpkc_in_if.sink    i_in,
    flpkc_out_if.source o_out
);
    import flpkc_pkg::*;

    logic push_valid, push_ready;
    t_job push_job;
    logic pop_valid, pop_ready;
    t_job pop_job;
    logic init_busy;

    flpkc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_init_busy  (init_busy),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    flpkc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    flpkc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PROBE_LIMIT   (PROBE_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_job   (pop_job),
        .o_out       (o_out),
        .o_init_busy (init_busy)
    );

endmodule

`default_nettype wire

### sv/flpkc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module flpkc_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    flpkc_in_if.sink         i_in,
    input  wire              i_init_busy,
    output logic             o_push_valid,
    input  wire              i_push_ready,
    output flpkc_pkg::t_job  o_push_job
);
    import flpkc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HASH = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job;
    logic [3:0]        r_byte;
    logic [79:0]       key_bytes;
    logic [7:0]        cur_byte;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] product;
    logic              in_xfer;

    assign i_in.ready   = (r_state == S_IDLE) && !i_init_busy;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign o_push_valid = (r_state == S_PUSH);
    assign o_push_job   = r_job;

    // Pick the current key byte and fold it into the hash
    assign key_bytes = {r_job.key_high, r_job.key_low};
    assign cur_byte  = key_bytes[{r_byte, 3'b000} +: 8];
    assign mixed     = r_job.hash ^ {24'd0, cur_byte};
    assign product   = mixed * FNV_PRIME;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_HASH;
            end
            S_HASH: begin
                if (r_byte == 4'(KEY_BYTES - 1)) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_push_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item, then advance the hash one byte per cycle
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_job.cmd      <= t_cmd'(i_in.command);
            r_job.key_low  <= i_in.key_low;
            r_job.key_high <= i_in.key_high;
            r_job.slot     <= i_in.slot_value;
            r_job.hash     <= FNV_BASIS;
            r_byte         <= 4'd0;
        end else if (r_state == S_HASH) begin
            r_job.hash <= product;
            r_byte     <= r_byte + 4'd1;
        end
    end

endmodule

`default_nettype wire

### sv/flpkc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module flpkc_queue #(
    parameter int DEPTH = flpkc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    output logic                 o_push_ready,
    input  wire flpkc_pkg::t_job i_push_job,
    output logic                 o_pop_valid,
    input  wire                  i_pop_ready,
    output flpkc_pkg::t_job      o_pop_job
);
    import flpkc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push_job;
    end

endmodule

`default_nettype wire

### sv/flpkc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module flpkc_back #(
    parameter int TABLE_ENTRIES = flpkc_pkg::DEF_TABLE_ENTRIES,
    parameter int PROBE_LIMIT   = flpkc_pkg::DEF_PROBE_LIMIT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_pop_valid,
    output logic                 o_pop_ready,
    input  wire flpkc_pkg::t_job i_pop_job,
    flpkc_out_if.source          o_out,
    output logic                 o_init_busy
);
    import flpkc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(PROBE_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_init, n_init;
    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd_data;
    logic              mem_we;
    t_entry            mem_wdata;
    logic              pop;
    logic              same_key;
    logic              set_out;
    logic              n_hit, n_evicted;
    logic [SLOT_W-1:0] n_slot;
    logic              r_out_valid, r_hit, r_evicted;
    logic [SLOT_W-1:0] r_slot;
    logic              out_free;

    assign out_free    = !r_out_valid || o_out.ready;
    assign o_pop_ready = (r_state == S_IDLE) && out_free;
    assign pop         = i_pop_valid && o_pop_ready;
    assign o_init_busy = r_init;

    assign same_key = (r_rd_data.key_low == r_job.key_low)
                   && (r_rd_data.key_high == r_job.key_high);

    // Probe and clear sequencer: one table read per cycle
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_init    = r_init;
        mem_we    = 1'b0;
        mem_wdata = '0;
        set_out   = 1'b0;
        n_hit     = 1'b0;
        n_slot    = '0;
        n_evicted = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == '1) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    case (i_pop_job.cmd)
                        CMD_GET, CMD_PUT: begin
                            n_idx   = i_pop_job.hash[IW-1:0];
                            n_cnt   = '0;
                            n_state = S_PROBE;
                        end
                        CMD_CLEAR: begin
                            set_out = 1'b1;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            set_out = 1'b1;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_job.cmd == CMD_PUT) begin
                    // Write at a free entry, the same key, or past the last probe
                    if (!r_rd_data.valid || same_key || r_cnt == CW'(PROBE_LIMIT)) begin
                        mem_we             = 1'b1;
                        mem_wdata.valid    = 1'b1;
                        mem_wdata.key_low  = r_job.key_low;
                        mem_wdata.key_high = r_job.key_high;
                        mem_wdata.slot     = r_job.slot;
                        n_evicted          = r_rd_data.valid && !same_key;
                        set_out            = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    // Lookup stops at a free entry, a match, or the last probe
                    if (r_rd_data.valid && same_key) begin
                        n_hit   = 1'b1;
                        n_slot  = r_rd_data.slot;
                        set_out = 1'b1;
                        n_state = S_IDLE;
                    end else if (!r_rd_data.valid || r_cnt == CW'(PROBE_LIMIT - 1)) begin
                        set_out = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
        end
    end

    // Hold the job under work
    always_ff @(posedge i_clk) begin
        if (pop) r_job <= i_pop_job;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_idx] <= mem_wdata;
        r_rd_data <= r_mem[n_idx];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (set_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_out) begin
            r_hit     <= n_hit;
            r_slot    <= n_slot;
            r_evicted <= n_evicted;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_hit;
    assign o_out.slot_found = r_slot;
    assign o_out.evicted    = r_evicted;

endmodule

`default_nettype wire

### sv/flpkc_check.sv
`timescale 1ns / 1ps
`default_nettype none

module flpkc_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_hit,
    input wire [15:0] i_out_slot_found,
    input wire        i_out_evicted
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit)
            && $stable(i_out_slot_found) && $stable(i_out_evicted))
        else $error("result changed while stalled");

    // A lookup hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_hit && i_out_evicted))
        else $error("hit and evicted both set");

    // Slot is zero unless the lookup hit
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_slot_found == 16'd0)
        else $error("slot_found nonzero without hit");

    // Reset drops results and starts the table sweep with input closed
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("activity right after reset");

endmodule

bind fnv_linear_probe_key_cache_top flpkc_check u_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_hit        (o_out.hit),
    .i_out_slot_found (o_out.slot_found),
    .i_out_evicted    (o_out.evicted)
);

`default_nettype wire
